// File: rtl/cbf_pkg.sv
// Shared types and constants for the block Cholesky factor.
`timescale 1ns / 1ps
`default_nettype none

package cbf_pkg;

  // Fraction bits of the Q16.16 number format
  localparam int FRAC_BITS = 16;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic mem_rd;      // read the store at row/col into the read register
    logic mem_wr;      // write the store at row/col
    logic wr_iter;     // write data: 1 = divide/root result, 0 = input item
    logic acc_load;    // accumulator <= read register
    logic opa_load;    // first multiplier operand <= read register
    logic mul_start;   // start a product of operand A and the read register
    logic acc_sub;     // accumulator <= sat(accumulator - product)
    logic iter_start;  // start the shared divide / square root unit
    logic iter_sqrt;   // 1 = square root of the accumulator, 0 = divide by pivot
    logic piv_load;    // pivot <= divide/root result
    logic out_zero;    // force the outgoing item to zero
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic mul_busy;
    logic iter_busy;
    logic acc_nonpos;
  } sts_t;

endpackage

`default_nettype wire

// File: rtl/cbf_iter.sv
// Shared iterative unit: restoring divide and digit-by-digit square root.
`timescale 1ns / 1ps
`default_nettype none

module cbf_iter #(
  parameter int DW = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic                 sqrt_op,
  input  wire logic signed [DW-1:0] a,
  input  wire logic signed [DW-1:0] dvs,
  output logic                      busy,
  output logic signed [DW-1:0]      res
);

  localparam int NW = DW + cbf_pkg::FRAC_BITS;
  localparam int SW = (DW + cbf_pkg::FRAC_BITS + 1) / 2;
  localparam int XW = 2 * SW;
  localparam int RW = DW + 3;
  localparam int CW = $clog2(XW + 1);
  localparam logic [NW-1:0] LIM_N = NW'(1) << (DW - 1);
  localparam logic [NW-1:0] MAX_N = LIM_N - NW'(1);
  localparam logic [DW-1:0] MAX_V = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] MIN_V = {1'b1, {(DW-1){1'b0}}};

  logic [XW-1:0] src_r, src_nxt;
  logic [RW-1:0] rem_r, rem_nxt;
  logic [NW-1:0] res_r, res_nxt;
  logic [CW-1:0] cnt_r;
  logic [DW-1:0] dvs_r;
  logic          busy_r, sqrt_r, neg_r;
  logic [DW-1:0] mag_a;
  logic [RW-1:0] rem_s, trial;
  logic          ge;

  assign mag_a = a[DW-1] ? (~a + 1'b1) : a;

  // One quotient bit or one root bit per cycle
  always_comb begin
    if (sqrt_r) begin
      rem_s = {rem_r[RW-3:0], src_r[XW-1:XW-2]};
      trial = {res_r[RW-3:0], 2'b01};
      src_nxt = src_r << 2;
    end else begin
      rem_s = {rem_r[RW-2:0], src_r[XW-1]};
      trial = RW'(dvs_r);
      src_nxt = src_r << 1;
    end
    ge = (rem_s >= trial);
    rem_nxt = ge ? (rem_s - trial) : rem_s;
    res_nxt = {res_r[NW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= sqrt_op ? CW'(SW) : CW'(NW);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // Operand and working registers
  always_ff @(posedge clk) begin
    if (start) begin
      sqrt_r <= sqrt_op;
      neg_r  <= a[DW-1] & ~sqrt_op;
      dvs_r  <= dvs;
      rem_r  <= '0;
      res_r  <= '0;
      if (sqrt_op) begin
        src_r <= XW'({mag_a, {cbf_pkg::FRAC_BITS{1'b0}}});
      end else begin
        src_r <= XW'({mag_a, {cbf_pkg::FRAC_BITS{1'b0}}}) << (XW - NW);
      end
    end else if (busy_r) begin
      src_r <= src_nxt;
      rem_r <= rem_nxt;
      res_r <= res_nxt;
    end
  end

  // Clamp the root, saturate the signed quotient
  always_comb begin
    if (sqrt_r || !neg_r) begin
      res = (res_r > MAX_N) ? MAX_V : res_r[DW-1:0];
    end else begin
      res = (res_r > LIM_N) ? MIN_V : (~res_r[DW-1:0] + 1'b1);
    end
  end

  assign busy = busy_r;

endmodule

`default_nettype wire

// File: rtl/cbf_dp.sv
// Datapath: block store, accumulator, serial multiplier and divide/root unit.
`timescale 1ns / 1ps
`default_nettype none

module cbf_dp #(
  parameter int MAX_BLOCK = 8,
  parameter int DW        = 32,
  parameter int IW        = 3
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire cbf_pkg::cmd_t   cmd,
  input  wire logic [IW-1:0]   row,
  input  wire logic [IW-1:0]   col,
  input  wire logic [31:0]     in_data,
  output cbf_pkg::sts_t        sts,
  output logic [31:0]          out_data
);

  localparam int DEPTH = MAX_BLOCK * MAX_BLOCK;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int EW    = (DW > 32) ? DW : 32;
  localparam int ND    = (DW + 15) / 16;
  localparam int UBW   = ND * 16;
  localparam int PW    = DW + UBW;
  localparam int MW    = PW - cbf_pkg::FRAC_BITS;
  localparam int MCW   = $clog2(ND + 1);
  localparam logic [DW-1:0] MAX_V = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] MIN_V = {1'b1, {(DW-1){1'b0}}};
  localparam logic [MW-1:0] LIM_M = MW'(1) << (DW - 1);
  localparam logic [MW-1:0] MAX_M = LIM_M - MW'(1);

  logic signed [DW-1:0] mem [DEPTH];
  logic signed [DW-1:0] rd_r, acc_r, opa_r, piv_r;
  logic [AW-1:0]        addr;
  logic signed [DW-1:0] wdata, in_sat, iter_res, qm;
  logic signed [31:0]   in_s;
  logic signed [EW-1:0] in_e, out_e;
  logic                 iter_busy;

  // Multiplier state
  logic [DW-1:0]  ua_r;
  logic [UBW-1:0] ub_r;
  logic [PW-1:0]  prod_r;
  logic [MCW-1:0] mcnt_r;
  logic           mbusy_r, mneg_r;
  logic [DW+15:0] pp;
  logic [MW-1:0]  mq;
  logic signed [DW:0] diff;

  assign addr = AW'(int'(row) * MAX_BLOCK + int'(col));

  // Saturate the input item to the data width
  assign in_s = in_data;
  assign in_e = EW'(in_s);
  always_comb begin
    if (in_e > EW'(signed'(MAX_V))) begin
      in_sat = MAX_V;
    end else if (in_e < EW'(signed'(MIN_V))) begin
      in_sat = MIN_V;
    end else begin
      in_sat = in_e[DW-1:0];
    end
  end

  assign wdata = cmd.wr_iter ? iter_res : in_sat;

  // Store: one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (cmd.mem_wr) begin
      mem[addr] <= wdata;
    end
    if (cmd.mem_rd) begin
      rd_r <= mem[addr];
    end
  end

  // Serial multiplier, 16 bits of the second operand a cycle
  assign pp = ua_r * ub_r[UBW-1 -: 16];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mbusy_r <= 1'b0;
      mcnt_r  <= '0;
    end else if (cmd.mul_start) begin
      mbusy_r <= 1'b1;
      mcnt_r  <= MCW'(ND);
    end else if (mbusy_r) begin
      mcnt_r <= mcnt_r - 1'b1;
      if (mcnt_r == MCW'(1)) begin
        mbusy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_start) begin
      ua_r   <= opa_r[DW-1] ? (~opa_r + 1'b1) : opa_r;
      ub_r   <= UBW'(rd_r[DW-1] ? (~rd_r + 1'b1) : rd_r);
      prod_r <= '0;
      mneg_r <= opa_r[DW-1] ^ rd_r[DW-1];
    end else if (mbusy_r) begin
      prod_r <= (prod_r << 16) + PW'(pp);
      ub_r   <= ub_r << 16;
    end
  end

  // Drop fraction bits and saturate the signed product
  assign mq = prod_r[PW-1:cbf_pkg::FRAC_BITS];
  always_comb begin
    if (mneg_r) begin
      qm = (mq > LIM_M) ? MIN_V : (~mq[DW-1:0] + 1'b1);
    end else begin
      qm = (mq > MAX_M) ? MAX_V : mq[DW-1:0];
    end
  end

  assign diff = {acc_r[DW-1], acc_r} - {qm[DW-1], qm};

  // Accumulator, operand and pivot registers
  always_ff @(posedge clk) begin
    if (cmd.acc_load) begin
      acc_r <= rd_r;
    end else if (cmd.acc_sub) begin
      if (diff[DW] != diff[DW-1]) begin
        acc_r <= diff[DW] ? MIN_V : MAX_V;
      end else begin
        acc_r <= diff[DW-1:0];
      end
    end
    if (cmd.opa_load) begin
      opa_r <= rd_r;
    end
    if (cmd.piv_load) begin
      piv_r <= iter_res;
    end
  end

  cbf_iter #(
    .DW (DW)
  ) u_iter (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.iter_start),
    .sqrt_op (cmd.iter_sqrt),
    .a       (acc_r),
    .dvs     (piv_r),
    .busy    (iter_busy),
    .res     (iter_res)
  );

  assign sts.mul_busy   = mbusy_r;
  assign sts.iter_busy  = iter_busy;
  assign sts.acc_nonpos = acc_r[DW-1] || (acc_r == '0);

  // Outgoing item: low 32 bits of the stored value, or zero when out_zero is set
  assign out_e    = EW'(rd_r);
  assign out_data = cmd.out_zero ? 32'd0 : out_e[31:0];

endmodule

`default_nettype wire

// File: rtl/cbf_ctrl.sv
// Controller: load, left-looking factor sequence and output sequencing.
`timescale 1ns / 1ps
`default_nettype none

module cbf_ctrl #(
  parameter int MAX_BLOCK = 8,
  parameter int IW        = 3
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_we,
  input  wire logic [3:0]    cfg_wdata,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output logic               out_err,
  output logic               out_last,
  input  wire cbf_pkg::sts_t sts,
  output cbf_pkg::cmd_t      cmd,
  output logic [IW-1:0]      row,
  output logic [IW-1:0]      col
);

  localparam logic [3:0] S_LOAD = 4'd0;
  localparam logic [3:0] S_RDV  = 4'd1;
  localparam logic [3:0] S_LDA  = 4'd2;
  localparam logic [3:0] S_RDA  = 4'd3;
  localparam logic [3:0] S_RDB  = 4'd4;
  localparam logic [3:0] S_MST  = 4'd5;
  localparam logic [3:0] S_MWT  = 4'd6;
  localparam logic [3:0] S_SUB  = 4'd7;
  localparam logic [3:0] S_PIV  = 4'd8;
  localparam logic [3:0] S_IWT  = 4'd9;
  localparam logic [3:0] S_WR   = 4'd10;
  localparam logic [3:0] S_ORD  = 4'd11;
  localparam logic [3:0] S_OVL  = 4'd12;

  logic [3:0]    st_r, st_nxt;
  logic [3:0]    sz_r;
  logic [IW-1:0] r_r, r_nxt, c_r, c_nxt;
  logic [IW-1:0] k_r, k_nxt, m_r, m_nxt, n_r, n_nxt;
  logic [IW-1:0] bad_r, bad_nxt;
  logic          err_r, err_nxt;
  logic [IW-1:0] bm1;

  // Effective edge length minus one
  always_comb begin
    if (sz_r == 4'd0) begin
      bm1 = '0;
    end else if (sz_r > 4'(MAX_BLOCK)) begin
      bm1 = IW'(MAX_BLOCK - 1);
    end else begin
      bm1 = IW'(sz_r - 4'd1);
    end
  end

  always_comb begin
    st_nxt  = st_r;
    r_nxt   = r_r;
    c_nxt   = c_r;
    k_nxt   = k_r;
    m_nxt   = m_r;
    n_nxt   = n_r;
    bad_nxt = bad_r;
    err_nxt = err_r;
    cmd     = '0;
    row     = m_r;
    col     = k_r;
    unique case (st_r)
      S_LOAD: begin
        row = r_r;
        col = c_r;
        if (in_tvalid) begin
          cmd.mem_wr = 1'b1;
          if (c_r == bm1) begin
            c_nxt = '0;
            if (r_r == bm1) begin
              r_nxt  = '0;
              k_nxt  = '0;
              m_nxt  = '0;
              st_nxt = S_RDV;
            end else begin
              r_nxt = r_r + 1'b1;
            end
          end else begin
            c_nxt = c_r + 1'b1;
          end
        end
      end
      S_RDV: begin
        cmd.mem_rd = 1'b1;
        st_nxt     = S_LDA;
      end
      S_LDA: begin
        cmd.acc_load = 1'b1;
        n_nxt        = '0;
        st_nxt       = (k_r == '0) ? S_PIV : S_RDA;
      end
      S_RDA: begin
        row        = k_r;
        col        = n_r;
        cmd.mem_rd = 1'b1;
        st_nxt     = S_RDB;
      end
      S_RDB: begin
        row          = m_r;
        col          = n_r;
        cmd.mem_rd   = 1'b1;
        cmd.opa_load = 1'b1;
        st_nxt       = S_MST;
      end
      S_MST: begin
        cmd.mul_start = 1'b1;
        st_nxt        = S_MWT;
      end
      S_MWT: begin
        if (!sts.mul_busy) begin
          st_nxt = S_SUB;
        end
      end
      S_SUB: begin
        cmd.acc_sub = 1'b1;
        if (n_r == k_r - 1'b1) begin
          st_nxt = S_PIV;
        end else begin
          n_nxt  = n_r + 1'b1;
          st_nxt = S_RDA;
        end
      end
      S_PIV: begin
        if (m_r == k_r && sts.acc_nonpos) begin
          err_nxt = 1'b1;
          bad_nxt = k_r;
          st_nxt  = S_ORD;
        end else begin
          cmd.iter_start = 1'b1;
          cmd.iter_sqrt  = (m_r == k_r);
          st_nxt         = S_IWT;
        end
      end
      S_IWT: begin
        if (!sts.iter_busy) begin
          st_nxt = S_WR;
        end
      end
      S_WR: begin
        cmd.mem_wr   = 1'b1;
        cmd.wr_iter  = 1'b1;
        cmd.piv_load = (m_r == k_r);
        if (m_r == bm1) begin
          if (k_r == bm1) begin
            st_nxt = S_ORD;
          end else begin
            k_nxt  = k_r + 1'b1;
            m_nxt  = k_r + 1'b1;
            st_nxt = S_RDV;
          end
        end else begin
          m_nxt  = m_r + 1'b1;
          st_nxt = S_RDV;
        end
      end
      S_ORD: begin
        row        = r_r;
        col        = c_r;
        cmd.mem_rd = 1'b1;
        st_nxt     = S_OVL;
      end
      S_OVL: begin
        row          = r_r;
        col          = c_r;
        cmd.out_zero = err_r && (c_r >= bad_r) && (c_r <= r_r);
        if (out_tready) begin
          if (c_r == bm1) begin
            c_nxt = '0;
            if (r_r == bm1) begin
              r_nxt   = '0;
              err_nxt = 1'b0;
              st_nxt  = S_LOAD;
            end else begin
              r_nxt  = r_r + 1'b1;
              st_nxt = S_ORD;
            end
          end else begin
            c_nxt  = c_r + 1'b1;
            st_nxt = S_ORD;
          end
        end
      end
      default: begin
        st_nxt = S_LOAD;
      end
    endcase
  end

  // Advance state; a size write clears the load position and the error flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_LOAD;
      sz_r  <= 4'd8;
      r_r   <= '0;
      c_r   <= '0;
      k_r   <= '0;
      m_r   <= '0;
      n_r   <= '0;
      bad_r <= '0;
      err_r <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      r_r   <= r_nxt;
      c_r   <= c_nxt;
      k_r   <= k_nxt;
      m_r   <= m_nxt;
      n_r   <= n_nxt;
      bad_r <= bad_nxt;
      err_r <= err_nxt;
      if (cfg_we) begin
        sz_r  <= cfg_wdata;
        r_r   <= '0;
        c_r   <= '0;
        err_r <= 1'b0;
      end
    end
  end

  assign in_tready  = (st_r == S_LOAD);
  assign out_tvalid = (st_r == S_OVL);
  assign out_err    = err_r;
  assign out_last   = (r_r == bm1) && (c_r == bm1);

`ifndef ASSERT_OFF
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input and output open together");

  a_mul_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_MST) |=> (st_r == S_MWT && sts.mul_busy))
    else $error("multiplier did not start");

  a_err_out: assert property (@(posedge clk) disable iff (!rst_n)
    err_r |-> (st_r == S_ORD || st_r == S_OVL))
    else $error("pivot error outside output phase");

  a_iter_start: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.iter_start |=> sts.iter_busy)
    else $error("divide/root unit did not start");
`endif

endmodule

`default_nettype wire

// File: rtl/cholesky_block_factor.sv
// Top level: block Cholesky factor with stream ports and a size register.
// Load: one item a cycle, b*b items. Factor: each product runs on the shared serial
//   multiplier; each pivot's square root and each division of an entry below it
//   run on the shared divide/root unit.
// Output: b*b items; each is read through the single read port of the store, then offered.
// Reset (rst_n low, synchronous): size 8, load position and error flag cleared;
//   the store is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module cholesky_block_factor #(
  parameter int MAX_BLOCK  = 8,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [3:0]  cfg_wdata,      // size_in_use
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,       // [31:0] element_value
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,      // [31:0] result_value
  output logic             out_tuser,      // [0] not_positive_definite
  output logic             out_tlast       // last_of_block
);

  localparam int IW = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;

  cbf_pkg::cmd_t cmd;
  cbf_pkg::sts_t sts;
  logic [IW-1:0] row, col;

  cbf_ctrl #(
    .MAX_BLOCK (MAX_BLOCK),
    .IW        (IW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_err    (out_tuser),
    .out_last   (out_tlast),
    .sts        (sts),
    .cmd        (cmd),
    .row        (row),
    .col        (col)
  );

  cbf_dp #(
    .MAX_BLOCK (MAX_BLOCK),
    .DW        (DATA_WIDTH),
    .IW        (IW)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .row      (row),
    .col      (col),
    .in_data  (in_tdata),
    .sts      (sts),
    .out_data (out_tdata)
  );

endmodule

`default_nettype wire

// File: tb/cholesky_block_factor_checker.sv
// Checker for the block Cholesky factor: predicts each block's output and compares it.
`timescale 1ns / 1ps

module cholesky_block_factor_checker #(
  parameter int MAX_BLOCK = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  input  logic        out_tuser,
  input  logic        out_tlast,
  output int          fail_count,
  output int          pending_count,
  output int          blocks_seen,
  output int          bad_blocks_seen
);

  localparam longint QMAX = 64'sd2147483647;
  localparam longint QMIN = -64'sd2147483648;

  typedef struct packed {
    logic [31:0] value;
    logic        not_pd;
    logic        last;
  } entry_t;

  entry_t      expected_q[$];
  logic [3:0]  block_size;
  int          fill_pos;
  longint      store[MAX_BLOCK * MAX_BLOCK];

  function automatic longint clamp_q(longint v);
    if (v > QMAX) return QMAX;
    if (v < QMIN) return QMIN;
    return v;
  endfunction

  function automatic longint unsigned mag_q(longint a);
    return (a < 0) ? longint'(-a) : longint'(a);
  endfunction

  // Apply a sign to a magnitude and saturate.
  function automatic longint apply_sign(bit neg, longint unsigned m);
    longint unsigned lim;
    lim = longint'(QMAX) + 1;
    if (neg) begin
      if (m > lim) m = lim;
      return -longint'(m);
    end
    if (m > longint'(QMAX)) return QMAX;
    return longint'(m);
  endfunction

  function automatic longint mul_q(longint a, longint b);
    bit                neg;
    longint unsigned   ua, ub, bh, bl, lim, m;
    neg = (a < 0) != (b < 0);
    ua  = mag_q(a);
    ub  = mag_q(b);
    bh  = ub >> 16;
    bl  = ub & 64'hFFFF;
    lim = longint'(QMAX) + 1;
    if (bh != 0 && ua > lim / bh) m = lim + 1;
    else m = ua * bh + ((ua * bl) >> 16);
    return apply_sign(neg, m);
  endfunction

  function automatic longint div_q(longint a, longint d);
    longint unsigned q;
    q = (mag_q(a) << 16) / longint'(d);
    return apply_sign(a < 0, q);
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned x);
    longint unsigned r, bt;
    r  = 0;
    bt = 64'd1 << 62;
    while (bt > x) bt >>= 2;
    while (bt != 0) begin
      if (x >= r + bt) begin
        x = x - (r + bt);
        r = (r >> 1) + bt;
      end else begin
        r >>= 1;
      end
      bt >>= 2;
    end
    return r;
  endfunction

  // Factor the loaded block in place and queue its output items.
  task automatic factor_and_queue(int b);
    int              bad_col;
    longint          d, v;
    longint unsigned p;
    entry_t          e;
    bad_col = -1;
    for (int k = 0; k < b; k++) begin
      d = store[k*b + k];
      for (int n = 0; n < k; n++) d = clamp_q(d - mul_q(store[k*b + n], store[k*b + n]));
      if (d <= 0) begin
        bad_col = k;
        break;
      end
      p = floor_sqrt(longint'(d) << 16);
      if (p > longint'(QMAX)) p = QMAX;
      store[k*b + k] = longint'(p);
      for (int m = k + 1; m < b; m++) begin
        v = store[m*b + k];
        for (int n = 0; n < k; n++) v = clamp_q(v - mul_q(store[m*b + n], store[k*b + n]));
        store[m*b + k] = div_q(v, longint'(p));
      end
    end
    if (bad_col >= 0)
      for (int i = 0; i < b; i++)
        for (int j = bad_col; j <= i; j++) store[i*b + j] = 0;
    for (int i = 0; i < b*b; i++) begin
      e.value  = store[i][31:0];
      e.not_pd = (bad_col >= 0);
      e.last   = (i == b*b - 1);
      expected_q.push_back(e);
    end
    blocks_seen++;
    if (bad_col >= 0) bad_blocks_seen++;
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count      = 0;
    blocks_seen     = 0;
    bad_blocks_seen = 0;
    block_size      = 4'd8;
    fill_pos        = 0;
  end

  assign pending_count = expected_q.size();

  // Track loads and configuration, compare outgoing items.
  always @(posedge clk) begin
    int     b;
    entry_t e;
    if (!rst_n) begin
      block_size = 4'd8;
      fill_pos   = 0;
    end else begin
      if (cfg_we) begin
        block_size = cfg_wdata;
        fill_pos   = 0;
      end
      if (in_tvalid && in_tready) begin
        b = (block_size == 0) ? 1 : (block_size > MAX_BLOCK) ? MAX_BLOCK : block_size;
        if (fill_pos >= b*b) fill_pos = 0;
        store[fill_pos] = longint'(signed'(in_tdata));
        fill_pos++;
        if (fill_pos == b*b) begin
          factor_and_queue(b);
          fill_pos = 0;
        end
      end
      if (out_tvalid && out_tready) begin
        if (expected_q.size() == 0) begin
          report("unexpected item", out_tdata, 32'h0);
        end else begin
          e = expected_q.pop_front();
          if (out_tdata !== e.value) report("result_value", out_tdata, e.value);
          if (out_tuser !== e.not_pd) report("not_positive_definite", out_tuser, e.not_pd);
          if (out_tlast !== e.last) report("last_of_block", out_tlast, e.last);
        end
      end
    end
  end

endmodule

// File: tb/cholesky_block_factor_tb.sv
// Testbench top for the block Cholesky factor: stimulus, stalls and verdict.
`timescale 1ns / 1ps

module cholesky_block_factor_tb;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [3:0]  cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  int fail_count, pending_count, blocks_seen, bad_blocks_seen;
  int items_sent;
  int sizes_used;
  bit quiet;
  int ready_stall;
  logic [31:0] mat[64];

  cholesky_block_factor i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  cholesky_block_factor_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .out_tlast       (out_tlast),
    .fail_count      (fail_count),
    .pending_count   (pending_count),
    .blocks_seen     (blocks_seen),
    .bad_blocks_seen (bad_blocks_seen)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Stall the result side in random bursts, never once the run is quiet.
  always @(posedge clk) begin
    if (quiet) begin
      out_tready <= 1'b1;
    end else if (ready_stall > 0) begin
      ready_stall <= ready_stall - 1;
      out_tready  <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      ready_stall <= $urandom_range(0, 16);
      out_tready  <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  initial begin
    #20000000;
    $display("Verification failed");
    $finish;
  end

  function automatic int edge_len(logic [3:0] v);
    return (v == 0) ? 1 : (v > 8) ? 8 : v;
  endfunction

  // Offer one item, with an optional random gap, and hold it until accepted.
  task automatic send(logic [31:0] v);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= v;
    forever begin
      @(negedge clk);
      if (in_tready) break;
    end
    @(posedge clk);
    items_sent++;
  endtask

  // Drop valid and hold until every expected item has come back.
  task automatic drain(int settle);
    in_tvalid <= 1'b0;
    forever begin
      @(negedge clk);
      if (pending_count == 0) break;
    end
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_size(logic [3:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sizes_used++;
  endtask

  // Build a block: mostly well conditioned, some noise, some with a bad pivot.
  task automatic make_block(int b);
    int kind, bad;
    kind = $urandom_range(0, 9);
    for (int i = 0; i < b; i++)
      for (int j = 0; j < b; j++) begin
        if (kind == 0 || j > i) mat[i*b + j] = $urandom;
        else if (j < i) mat[i*b + j] = int'($urandom_range(0, 1 << 18)) - (1 << 17);
        else mat[i*b + j] = b * (1 << 17) + $urandom_range(0, 1 << 20);
      end
    if (kind == 1) begin
      bad = $urandom_range(0, b - 1);
      mat[bad*b + bad] = ($urandom_range(0, 1) == 0) ? 32'h0 : -$urandom_range(1, 1 << 30);
    end
  endtask

  task automatic send_block(int b);
    for (int i = 0; i < b*b; i++) send(mat[i]);
  endtask

  initial begin
    logic [3:0] sz;
    int         b, nblk;
    int         preset[4] = '{4'd8, 4'd15, 4'd0, 4'd3};
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_wdata   = 4'd0;
    in_tvalid   = 1'b0;
    in_tdata    = 32'h0;
    out_tready  = 1'b0;
    ready_stall = 0;
    quiet       = 1'b0;
    items_sent  = 0;
    sizes_used  = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Single-entry blocks: extremes, zero pivot, one, smallest positive.
    write_size(4'd1);
    send(32'h7FFF_FFFF);
    send(32'h8000_0000);
    send(32'h0000_0000);
    send(32'h0001_0000);
    send(32'h0000_0001);
    drain(10);

    // Partial block discarded by a size write.
    write_size(4'd2);
    send(32'h1234_5678);
    drain(50);
    write_size(4'd2);

    // 2x2: a good block, then one whose second pivot goes negative.
    send(32'h0004_0000); send(32'hDEAD_BEEF); send(32'h0002_0000); send(32'h0005_0000);
    send(32'h0001_0000); send(32'h0000_0000); send(32'h0003_0000); send(32'h0001_0000);
    drain(10);

    // Random phases, each ending with the sender held until all results are back.
    for (int ph = 0; items_sent < 130 || ph < 4; ph++) begin
      if (ph < 4) sz = preset[ph];
      else if ($urandom_range(0, 3) == 0) sz = $urandom_range(0, 15);
      else sz = $urandom_range(1, 4);
      if (items_sent >= 110) quiet = 1'b1;
      write_size(sz);
      b    = edge_len(sz);
      nblk = (b >= 6) ? 1 : $urandom_range(1, 3);
      for (int k = 0; k < nblk; k++) begin
        make_block(b);
        send_block(b);
      end
      drain(10);
    end

    drain(200);
    $display("Sent %0d items over %0d size settings (edge 1 to 8, including 0 and 15).",
             items_sent, sizes_used);
    $display("Factored %0d blocks, %0d of them with a non-positive pivot.",
             blocks_seen, bad_blocks_seen);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: cholesky_block_factor.f
rtl/cbf_pkg.sv
rtl/cbf_iter.sv
rtl/cbf_dp.sv
rtl/cbf_ctrl.sv
rtl/cholesky_block_factor.sv
tb/cholesky_block_factor_checker.sv
tb/cholesky_block_factor_tb.sv
